[hdl/sha1_pkg.sv]
// Shared types, constants and helper functions for the SHA-1 digest core.
// Used by sha1_ctrl, sha1_dp and sha1_message_digest_core. No dependencies.
package sha1_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned LEN_W    = 64;
    localparam int unsigned CNT_W    = 3;
    localparam int unsigned POS_W    = 4;
    localparam int unsigned HASH_N   = 5;
    localparam int unsigned WIN_N    = 16;
    localparam int unsigned ROUNDS   = 80;
    localparam int unsigned ROUND_W  = $clog2(ROUNDS);
    localparam int unsigned BYTES_PW = 4;

    // Initial chaining values H0..H4
    localparam logic [WORD_W-1:0] INIT_H [HASH_N] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    // Round constants, one per group of twenty rounds
    localparam logic [WORD_W-1:0] K_0 = 32'h5A827999;
    localparam logic [WORD_W-1:0] K_1 = 32'h6ED9EBA1;
    localparam logic [WORD_W-1:0] K_2 = 32'h8F1BBCDC;
    localparam logic [WORD_W-1:0] K_3 = 32'hCA62C1D6;

    // Padding byte placed in the first byte lane
    localparam logic [WORD_W-1:0] PAD_WORD = 32'h80000000;

    // Source of a word written into the schedule window
    typedef enum logic [2:0] {
        SRC_INPUT,
        SRC_PAD,
        SRC_ZERO,
        SRC_LEN_HI,
        SRC_LEN_LO
    } put_src_t;

    // Round group selects the logic function and constant
    typedef enum logic [1:0] {
        STG_CHOOSE,
        STG_PARITY_A,
        STG_MAJORITY,
        STG_PARITY_B
    } stage_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic     put;        // shift a word into the schedule window
        put_src_t src;        // which word to shift in
        logic     add_len;    // add the input word's bits to the length
        logic     load_work;  // copy chaining values into working values
        logic     round;      // run one compression round
        stage_t   stage;      // round group of this round
        logic     add_chain;  // fold working values into chaining values
        logic     emit;       // load digest outputs and reset message state
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic pos_is_15;      // next put fills the block
        logic pos_is_14;      // two slots left: room for the length
        logic in_full;        // input word carries all four bytes
    } dp_sts_t;

    function automatic logic [WORD_W-1:0] rotl1(input logic [WORD_W-1:0] x);
        rotl1 = {x[WORD_W-2:0], x[WORD_W-1]};
    endfunction

    function automatic logic [WORD_W-1:0] rotl5(input logic [WORD_W-1:0] x);
        rotl5 = {x[WORD_W-6:0], x[WORD_W-1:WORD_W-5]};
    endfunction

    function automatic logic [WORD_W-1:0] rotl30(input logic [WORD_W-1:0] x);
        rotl30 = {x[1:0], x[WORD_W-1:2]};
    endfunction

endpackage

[hdl/sha1_dp.sv]
// Datapath of the SHA-1 digest core: schedule window, round logic,
// chaining values, length counter and digest output registers.
// Depends on sha1_pkg; driven by commands from sha1_ctrl.
module sha1_dp
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  sha1_pkg::dp_cmd_t             cmd,
    output sha1_pkg::dp_sts_t             sts,
    input  logic [sha1_pkg::WORD_W-1:0]   data_word,
    input  logic [sha1_pkg::CNT_W-1:0]    byte_count,
    input  logic                          last,
    output logic [sha1_pkg::WORD_W-1:0]   digest_word_0,
    output logic [sha1_pkg::WORD_W-1:0]   digest_word_1,
    output logic [sha1_pkg::WORD_W-1:0]   digest_word_2,
    output logic [sha1_pkg::WORD_W-1:0]   digest_word_3,
    output logic [sha1_pkg::WORD_W-1:0]   digest_word_4
);

    logic [sha1_pkg::WORD_W-1:0] win_reg   [sha1_pkg::WIN_N];
    logic [sha1_pkg::WORD_W-1:0] work_reg  [sha1_pkg::HASH_N];
    logic [sha1_pkg::WORD_W-1:0] chain_reg [sha1_pkg::HASH_N];
    logic [sha1_pkg::WORD_W-1:0] dig_reg   [sha1_pkg::HASH_N];
    logic [sha1_pkg::LEN_W-1:0]  len_reg;
    logic [sha1_pkg::POS_W-1:0]  pos_reg;

    logic [sha1_pkg::CNT_W-1:0]  cnt;
    logic [sha1_pkg::WORD_W-1:0] keep_mask;
    logic [sha1_pkg::WORD_W-1:0] pad_bit;
    logic [sha1_pkg::WORD_W-1:0] in_word;
    logic [sha1_pkg::LEN_W-1:0]  len_inc;
    logic [sha1_pkg::WORD_W-1:0] put_word;
    logic [sha1_pkg::WORD_W-1:0] sched_new;
    logic [sha1_pkg::WORD_W-1:0] fn;
    logic [sha1_pkg::WORD_W-1:0] k;
    logic [sha1_pkg::WORD_W-1:0] temp;
    logic [sha1_pkg::WORD_W-1:0] shift_in;

    // Clamp the byte count and shape the last word
    always_comb
    begin
        cnt = (byte_count > sha1_pkg::CNT_W'(sha1_pkg::BYTES_PW))
            ? sha1_pkg::CNT_W'(sha1_pkg::BYTES_PW) : byte_count;
        case (cnt)
            3'd0:    begin keep_mask = 32'h00000000; pad_bit = 32'h80000000; end
            3'd1:    begin keep_mask = 32'hFF000000; pad_bit = 32'h00800000; end
            3'd2:    begin keep_mask = 32'hFFFF0000; pad_bit = 32'h00008000; end
            3'd3:    begin keep_mask = 32'hFFFFFF00; pad_bit = 32'h00000080; end
            default: begin keep_mask = 32'hFFFFFFFF; pad_bit = 32'h00000000; end
        endcase
        if (last)
        begin
            in_word = (data_word & keep_mask) | pad_bit;
            len_inc = {{(sha1_pkg::LEN_W-sha1_pkg::CNT_W-3){1'b0}}, cnt, 3'b000};
        end
        else
        begin
            in_word = data_word;
            len_inc = sha1_pkg::LEN_W'(sha1_pkg::WORD_W);
        end
    end

    // Select the word to shift into the window
    always_comb
    begin
        unique case (cmd.src)
            sha1_pkg::SRC_INPUT:  put_word = in_word;
            sha1_pkg::SRC_PAD:    put_word = sha1_pkg::PAD_WORD;
            sha1_pkg::SRC_ZERO:   put_word = '0;
            sha1_pkg::SRC_LEN_HI: put_word = len_reg[sha1_pkg::LEN_W-1:sha1_pkg::WORD_W];
            sha1_pkg::SRC_LEN_LO: put_word = len_reg[sha1_pkg::WORD_W-1:0];
            default:              put_word = '0;
        endcase
    end

    // Message schedule: window holds W[t..t+15], oldest at index 0
    assign sched_new = sha1_pkg::rotl1(win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0]);
    assign shift_in  = cmd.put ? put_word : sched_new;

    // Round function and constant
    always_comb
    begin
        unique case (cmd.stage)
            sha1_pkg::STG_CHOOSE:
            begin
                fn = (work_reg[1] & work_reg[2]) | (~work_reg[1] & work_reg[3]);
                k  = sha1_pkg::K_0;
            end
            sha1_pkg::STG_PARITY_A:
            begin
                fn = work_reg[1] ^ work_reg[2] ^ work_reg[3];
                k  = sha1_pkg::K_1;
            end
            sha1_pkg::STG_MAJORITY:
            begin
                fn = (work_reg[1] & work_reg[2]) | (work_reg[1] & work_reg[3])
                   | (work_reg[2] & work_reg[3]);
                k  = sha1_pkg::K_2;
            end
            default:
            begin
                fn = work_reg[1] ^ work_reg[2] ^ work_reg[3];
                k  = sha1_pkg::K_3;
            end
        endcase
        temp = sha1_pkg::rotl5(work_reg[0]) + fn + work_reg[4] + win_reg[0] + k;
    end

    // Shift the window on a put or a round
    always_ff @(posedge clk)
    begin
        if (cmd.put || cmd.round)
        begin
            for (int i = 0; i < sha1_pkg::WIN_N - 1; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[sha1_pkg::WIN_N-1] <= shift_in;
        end
    end

    // Load or advance the working values
    always_ff @(posedge clk)
    begin
        if (cmd.load_work)
        begin
            for (int i = 0; i < sha1_pkg::HASH_N; i++)
            begin
                work_reg[i] <= chain_reg[i];
            end
        end
        else if (cmd.round)
        begin
            work_reg[0] <= temp;
            work_reg[1] <= work_reg[0];
            work_reg[2] <= sha1_pkg::rotl30(work_reg[1]);
            work_reg[3] <= work_reg[2];
            work_reg[4] <= work_reg[3];
        end
    end

    // Hold the digest words for the output channel
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            for (int i = 0; i < sha1_pkg::HASH_N; i++)
            begin
                dig_reg[i] <= chain_reg[i];
            end
        end
    end

    // Chaining values, length and fill position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sha1_pkg::HASH_N; i++)
            begin
                chain_reg[i] <= sha1_pkg::INIT_H[i];
            end
            len_reg <= '0;
            pos_reg <= '0;
        end
        else
        begin
            if (cmd.emit)
            begin
                for (int i = 0; i < sha1_pkg::HASH_N; i++)
                begin
                    chain_reg[i] <= sha1_pkg::INIT_H[i];
                end
            end
            else if (cmd.add_chain)
            begin
                for (int i = 0; i < sha1_pkg::HASH_N; i++)
                begin
                    chain_reg[i] <= chain_reg[i] + work_reg[i];
                end
            end

            if (cmd.emit)
            begin
                len_reg <= '0;
            end
            else if (cmd.add_len)
            begin
                len_reg <= len_reg + len_inc;
            end

            if (cmd.emit)
            begin
                pos_reg <= '0;
            end
            else if (cmd.put)
            begin
                pos_reg <= pos_reg + 1'b1;
            end
        end
    end

    assign sts.pos_is_15 = (pos_reg == sha1_pkg::POS_W'(sha1_pkg::WIN_N - 1));
    assign sts.pos_is_14 = (pos_reg == sha1_pkg::POS_W'(sha1_pkg::WIN_N - 2));
    assign sts.in_full   = (cnt == sha1_pkg::CNT_W'(sha1_pkg::BYTES_PW));

    assign digest_word_0 = dig_reg[0];
    assign digest_word_1 = dig_reg[1];
    assign digest_word_2 = dig_reg[2];
    assign digest_word_3 = dig_reg[3];
    assign digest_word_4 = dig_reg[4];

endmodule

[hdl/sha1_ctrl.sv]
// Controller of the SHA-1 digest core: input acceptance, padding sequence,
// round counter and output valid. Depends on sha1_pkg; drives sha1_dp.
module sha1_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              last,
    output logic              out_valid,
    input  logic              out_stall,
    input  sha1_pkg::dp_sts_t sts,
    output sha1_pkg::dp_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_COMP,
        S_ADD,
        S_OUT
    } state_t;

    typedef enum logic [2:0] {
        PH_NONE,
        PH_BYTE80,
        PH_ZEROS,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_DONE
    } phase_t;

    state_t                       state_reg, state_next;
    phase_t                       phase_reg, phase_next;
    logic [sha1_pkg::ROUND_W-1:0] round_reg, round_next;
    logic                         out_valid_reg, out_valid_next;

    localparam logic [sha1_pkg::ROUND_W-1:0] LAST_ROUND = sha1_pkg::ROUND_W'(sha1_pkg::ROUNDS - 1);
    localparam logic [sha1_pkg::ROUND_W-1:0] GRP_1 = sha1_pkg::ROUND_W'(sha1_pkg::ROUNDS / 4);
    localparam logic [sha1_pkg::ROUND_W-1:0] GRP_2 = sha1_pkg::ROUND_W'(sha1_pkg::ROUNDS / 2);
    localparam logic [sha1_pkg::ROUND_W-1:0] GRP_3 = sha1_pkg::ROUND_W'(3 * sha1_pkg::ROUNDS / 4);

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and datapath commands
    always_comb
    begin
        cmd            = '0;
        cmd.src        = sha1_pkg::SRC_INPUT;
        cmd.stage      = sha1_pkg::STG_CHOOSE;
        state_next     = state_reg;
        phase_next     = phase_reg;
        round_next     = '0;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.put     = 1'b1;
                    cmd.src     = sha1_pkg::SRC_INPUT;
                    cmd.add_len = 1'b1;
                    if (last)
                    begin
                        phase_next = sts.in_full ? PH_BYTE80 : PH_ZEROS;
                        state_next = S_PAD;
                    end
                end
            end

            S_PAD:
            begin
                unique case (phase_reg)
                    PH_BYTE80:
                    begin
                        cmd.put    = 1'b1;
                        cmd.src    = sha1_pkg::SRC_PAD;
                        phase_next = PH_ZEROS;
                    end
                    PH_ZEROS:
                    begin
                        if (sts.pos_is_14)
                        begin
                            phase_next = PH_LEN_HI;
                        end
                        else
                        begin
                            cmd.put = 1'b1;
                            cmd.src = sha1_pkg::SRC_ZERO;
                        end
                    end
                    PH_LEN_HI:
                    begin
                        cmd.put    = 1'b1;
                        cmd.src    = sha1_pkg::SRC_LEN_HI;
                        phase_next = PH_LEN_LO;
                    end
                    PH_LEN_LO:
                    begin
                        cmd.put    = 1'b1;
                        cmd.src    = sha1_pkg::SRC_LEN_LO;
                        phase_next = PH_DONE;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_COMP:
            begin
                cmd.round = 1'b1;
                if (round_reg < GRP_1)
                begin
                    cmd.stage = sha1_pkg::STG_CHOOSE;
                end
                else if (round_reg < GRP_2)
                begin
                    cmd.stage = sha1_pkg::STG_PARITY_A;
                end
                else if (round_reg < GRP_3)
                begin
                    cmd.stage = sha1_pkg::STG_MAJORITY;
                end
                else
                begin
                    cmd.stage = sha1_pkg::STG_PARITY_B;
                end
                if (round_reg == LAST_ROUND)
                begin
                    state_next = S_ADD;
                end
                else
                begin
                    round_next = round_reg + 1'b1;
                end
            end

            S_ADD:
            begin
                cmd.add_chain = 1'b1;
                if (phase_reg == PH_DONE)
                begin
                    state_next = S_OUT;
                end
                else if (phase_reg == PH_NONE)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_PAD;
                end
            end

            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    phase_next     = PH_NONE;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A put into the last slot starts the compression
        if (cmd.put && sts.pos_is_15)
        begin
            cmd.load_work = 1'b1;
            state_next    = S_COMP;
        end
    end

    // Hold state, phase, round count and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_NONE;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A pending digest is never overwritten while the receiver stalls
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(out_valid_reg && out_stall))
        else $error("digest loaded over a stalled result");

    // Round counter stays in range during compression
    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMP) |-> (round_reg <= LAST_ROUND))
        else $error("round counter out of range");

    // Compression starts only once the block is full
    a_comp_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_COMP && state_next == S_COMP) |-> (cmd.put && sts.pos_is_15))
        else $error("compression started on a partial block");

    // A last word is followed by padding, never by another input word
    a_last_pads: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && last) |=> in_stall)
        else $error("input accepted right after a last word");

    // Rounds always begin from round zero
    a_round_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_COMP) |=> (state_reg != S_COMP || round_reg == '0))
        else $error("compression entered with nonzero round count");

endmodule

[hdl/sha1_message_digest_core.sv]
// SHA-1 message digest core: top level joining controller and datapath.
// Depends on sha1_pkg, sha1_ctrl and sha1_dp.
//
// Usage: the message enters as big-endian 32-bit words on the input channel
// (data_word, byte_count, last; in_valid / in_stall). A word is taken at a
// clock edge with in_valid high and in_stall low. Only the word marked last
// may carry fewer than four bytes; byte_count above four counts as four.
// Each digest leaves on the output channel (digest_word_0..4; out_valid /
// out_stall) and the core is then ready for the next message.
// Rate: a word that does not fill a 16-word block leaves the input ready for
// the next word. The word that fills a block starts 80 rounds of the shared
// round unit, one round per cycle, and then the chaining values are folded
// in; the input stalls meanwhile. After the last word the padding words go
// in, with one or two compressions, and the digest is loaded after the last
// fold, once the output register is free.
// The digest sits in an output register: while the receiver stalls it holds,
// and the next message is accepted meanwhile; only the following digest waits.
// Reset (rst_n, asynchronous, active low) restores the initial chaining
// values, clears the length and empties the output.
module sha1_message_digest_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [sha1_pkg::WORD_W-1:0] data_word,
    input  logic [sha1_pkg::CNT_W-1:0]  byte_count,
    input  logic                        last,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [sha1_pkg::WORD_W-1:0] digest_word_0,
    output logic [sha1_pkg::WORD_W-1:0] digest_word_1,
    output logic [sha1_pkg::WORD_W-1:0] digest_word_2,
    output logic [sha1_pkg::WORD_W-1:0] digest_word_3,
    output logic [sha1_pkg::WORD_W-1:0] digest_word_4
);

    sha1_pkg::dp_cmd_t cmd;
    sha1_pkg::dp_sts_t sts;

    // Sequence words, padding, rounds and output
    sha1_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Hold the schedule, working and chaining values
    sha1_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .data_word     (data_word),
        .byte_count    (byte_count),
        .last          (last),
        .digest_word_0 (digest_word_0),
        .digest_word_1 (digest_word_1),
        .digest_word_2 (digest_word_2),
        .digest_word_3 (digest_word_3),
        .digest_word_4 (digest_word_4)
    );

endmodule

[test/sha1_message_digest_core_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for sha1_message_digest_core: streams messages as words,
// predicts each SHA-1 digest in place and compares every returned digest.
// Depends on sha1_pkg and the sha1_message_digest_core RTL.
module sha1_message_digest_core_test;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 250;
    localparam int LONG_HOLD     = 400;
    localparam int NUM_HOLDS     = 2;

    typedef logic [sha1_pkg::HASH_N-1:0][sha1_pkg::WORD_W-1:0] digest_t;

    typedef struct {
        logic [sha1_pkg::WORD_W-1:0] word;
        logic [sha1_pkg::CNT_W-1:0]  cnt;
        logic                        fin;
        logic                        hold;   // wait for every digest before offering
    } msg_word_t;

    typedef enum int {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY,
        RX_TOGGLE
    } rx_mode_t;

    logic                        clk        = 1'b0;
    logic                        rst_n      = 1'b0;
    logic                        in_valid   = 1'b0;
    logic                        in_stall;
    logic [sha1_pkg::WORD_W-1:0] data_word  = '0;
    logic [sha1_pkg::CNT_W-1:0]  byte_count = '0;
    logic                        last       = 1'b0;
    logic                        out_valid;
    logic                        out_stall  = 1'b0;
    logic [sha1_pkg::WORD_W-1:0] digest_word_0;
    logic [sha1_pkg::WORD_W-1:0] digest_word_1;
    logic [sha1_pkg::WORD_W-1:0] digest_word_2;
    logic [sha1_pkg::WORD_W-1:0] digest_word_3;
    logic [sha1_pkg::WORD_W-1:0] digest_word_4;

    // Predicted hash state
    logic [sha1_pkg::WORD_W-1:0] run_h [sha1_pkg::HASH_N];
    logic [sha1_pkg::WORD_W-1:0] blk_w [sha1_pkg::WIN_N];
    logic [sha1_pkg::LEN_W-1:0]  msg_bits;
    logic [sha1_pkg::POS_W-1:0]  slot;

    msg_word_t pend_q [$];
    digest_t   digest_q [$];

    int       fail_cnt     = 0;
    int       cycle_cnt    = 0;
    int       n_items      = 0;
    int       n_msgs       = 0;
    int       digests_seen = 0;
    logic     word_taken   = 1'b0;
    int       gap_left     = 0;
    int       burst_left   = 0;
    int       hold_left    = 0;
    int       holds_done   = 0;
    int       mode_left    = 0;
    rx_mode_t rx_mode      = RX_OPEN;

    sha1_message_digest_core u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_word     (data_word),
        .byte_count    (byte_count),
        .last          (last),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .digest_word_0 (digest_word_0),
        .digest_word_1 (digest_word_1),
        .digest_word_2 (digest_word_2),
        .digest_word_3 (digest_word_3),
        .digest_word_4 (digest_word_4)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [sha1_pkg::WORD_W-1:0] rol(input logic [sha1_pkg::WORD_W-1:0] x,
                                                        input int n);
        return (x << n) | (x >> (sha1_pkg::WORD_W - n));
    endfunction

    // Start a new message from the initial chaining values
    task automatic restart_hash();
        int i;
        for (i = 0; i < sha1_pkg::HASH_N; i++)
            run_h[i] = sha1_pkg::INIT_H[i];
        msg_bits = '0;
        slot     = '0;
    endtask

    // Run the 80 rounds over the current block and fold into the chain
    task automatic compress_block();
        logic [sha1_pkg::WORD_W-1:0] a, b, c, d, e, f, k, t, x;
        logic [sha1_pkg::WORD_W-1:0] w [sha1_pkg::WIN_N];
        int i;
        w = blk_w;
        a = run_h[0];
        b = run_h[1];
        c = run_h[2];
        d = run_h[3];
        e = run_h[4];
        for (i = 0; i < sha1_pkg::ROUNDS; i++)
        begin
            if (i >= sha1_pkg::WIN_N)
            begin
                x = w[(i - 3) & 15] ^ w[(i - 8) & 15] ^ w[(i - 14) & 15] ^ w[i & 15];
                w[i & 15] = rol(x, 1);
            end
            if (i < 20)
            begin
                f = (b & c) | (~b & d);
                k = sha1_pkg::K_0;
            end
            else if (i < 40)
            begin
                f = b ^ c ^ d;
                k = sha1_pkg::K_1;
            end
            else if (i < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = sha1_pkg::K_2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = sha1_pkg::K_3;
            end
            t = rol(a, 5) + f + e + w[i & 15] + k;
            e = d;
            d = c;
            c = rol(b, 30);
            b = a;
            a = t;
        end
        run_h[0] += a;
        run_h[1] += b;
        run_h[2] += c;
        run_h[3] += d;
        run_h[4] += e;
    endtask

    task automatic push_block_word(input logic [sha1_pkg::WORD_W-1:0] w);
        blk_w[slot] = w;
        slot = slot + 1'b1;
        if (slot == 0)
            compress_block();
    endtask

    // Absorb one accepted word; on the last word pad, finish and queue the digest
    task automatic absorb_word(input logic [sha1_pkg::WORD_W-1:0] w,
                               input logic [sha1_pkg::CNT_W-1:0] cnt,
                               input logic fin);
        int                          n;
        logic [sha1_pkg::WORD_W-1:0] kept;
        digest_t                     dig;
        int                          i;
        if (!fin)
        begin
            msg_bits += sha1_pkg::LEN_W'(sha1_pkg::WORD_W);
            push_block_word(w);
        end
        else
        begin
            n = (cnt > sha1_pkg::BYTES_PW) ? sha1_pkg::BYTES_PW : int'(cnt);
            msg_bits += sha1_pkg::LEN_W'(8 * n);
            // drop the bytes past the count
            kept = w & ~(32'hFFFFFFFF >> (8 * n));
            if (n == sha1_pkg::BYTES_PW)
            begin
                push_block_word(kept);
                push_block_word(sha1_pkg::PAD_WORD);
            end
            else
                push_block_word(kept | (sha1_pkg::PAD_WORD >> (8 * n)));
            if (slot == 15)
                push_block_word('0);
            while (slot != 14)
                push_block_word('0);
            push_block_word(msg_bits[sha1_pkg::LEN_W-1:sha1_pkg::WORD_W]);
            push_block_word(msg_bits[sha1_pkg::WORD_W-1:0]);
            for (i = 0; i < sha1_pkg::HASH_N; i++)
                dig[i] = run_h[i];
            digest_q.push_back(dig);
            restart_hash();
        end
    endtask

    // Stimulus helpers
    function automatic logic [sha1_pkg::WORD_W-1:0] pick_data();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom;
    endfunction

    task automatic queue_word(input logic [sha1_pkg::WORD_W-1:0] w,
                              input logic [sha1_pkg::CNT_W-1:0] cnt,
                              input logic fin, input logic hold);
        msg_word_t m;
        m.word = w;
        m.cnt  = cnt;
        m.fin  = fin;
        m.hold = hold;
        pend_q.push_back(m);
        n_items++;
    endtask

    task automatic queue_message(input int n_body, input logic [sha1_pkg::CNT_W-1:0] tail_cnt,
                                 input logic hold);
        int i;
        for (i = 0; i < n_body; i++)
            queue_word(pick_data(), sha1_pkg::CNT_W'($urandom_range(0, 7)), 1'b0,
                       hold && i == 0);
        queue_word(pick_data(), tail_cnt, 1'b1, hold && n_body == 0);
        n_msgs++;
    endtask

    function automatic int pick_body_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return $urandom_range(0, 6);
        if (r < 7)
            return $urandom_range(12, 17);
        if (r < 9)
            return $urandom_range(7, 30);
        return $urandom_range(31, 70);
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(1, 12);
    endfunction

    // Sender: offer words in bursts, hold a stalled word steady
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || word_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pend_q.size() > 0 && (!pend_q[0].hold || digest_q.size() == 0))
            begin
                in_valid   <= 1'b1;
                data_word  <= pend_q[0].word;
                byte_count <= pend_q[0].cnt;
                last       <= pend_q[0].fin;
                if (burst_left > 1)
                    burst_left = burst_left - 1;
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = pick_gap();
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random stall pattern plus a few long hold-offs
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (holds_done < NUM_HOLDS && in_valid
                 && digests_seen >= (holds_done == 0 ? 6 : 30))
        begin
            hold_left  = LONG_HOLD - 1;
            holds_done = holds_done + 1;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 80);
            end
            else
                mode_left = mode_left - 1;
            case (rx_mode)
                RX_OPEN:   out_stall <= 1'b0;
                RX_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
                default:   out_stall <= !out_stall;
            endcase
        end
    end

    // Monitor: predict on accepted words, check accepted digests
    always @(posedge clk)
    begin
        digest_t exp_dig;
        digest_t got_dig;
        int      i;
        if (!rst_n)
            word_taken <= 1'b0;
        else
        begin
            word_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                absorb_word(data_word, byte_count, last);
                void'(pend_q.pop_front());
            end
            if (out_valid && !out_stall)
            begin
                digests_seen = digests_seen + 1;
                got_dig = {digest_word_4, digest_word_3, digest_word_2, digest_word_1,
                           digest_word_0};
                if (digest_q.size() == 0)
                begin
                    $error("digest with no message pending: %h", got_dig);
                    fail_cnt = fail_cnt + 1;
                end
                else
                begin
                    exp_dig = digest_q.pop_front();
                    for (i = 0; i < sha1_pkg::HASH_N; i++)
                    begin
                        if (got_dig[i] !== exp_dig[i])
                        begin
                            $error("digest_word_%0d: expected %h, got %h", i, exp_dig[i],
                                   got_dig[i]);
                            fail_cnt = fail_cnt + 1;
                        end
                    end
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("[sha1_message_digest_core] ERROR");
            $finish;
        end
    end

    initial
    begin
        int i;
        restart_hash();

        // Directed: empty message with junk, short tails, oversize counts
        queue_word(32'hFFFFFFFF, 3'd0, 1'b1, 1'b0);
        queue_word(32'h616263A5, 3'd3, 1'b1, 1'b0);
        queue_word(32'hFFFFFFFF, 3'd1, 1'b1, 1'b0);
        queue_word(32'h00000000, 3'd2, 1'b1, 1'b0);
        queue_word(32'hFFFFFFFF, 3'd4, 1'b1, 1'b0);
        queue_word(32'h12345678, 3'd7, 1'b1, 1'b0);
        queue_word(32'h89ABCDEF, 3'd5, 1'b1, 1'b0);
        // 56-byte remainder forces a second padding block; counts ignored mid-message
        for (i = 0; i < 13; i++)
            queue_word((i % 2 == 0) ? 32'hFFFFFFFF : 32'h00000000,
                       sha1_pkg::CNT_W'(i % 8), 1'b0, 1'b0);
        queue_word(32'hA5A5A5A5, 3'd4, 1'b1, 1'b0);
        n_msgs = 8;

        // Random messages; drain the block before the first one and now and then
        queue_message(pick_body_len(), sha1_pkg::CNT_W'($urandom_range(0, 7)), 1'b1);
        while (n_items < 620 || n_msgs < 55)
            queue_message(pick_body_len(), sha1_pkg::CNT_W'($urandom_range(0, 7)),
                          $urandom_range(0, 11) == 0);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pend_q.size() != 0)
            @(posedge clk);
        while (digest_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_cnt == 0)
            $display("[sha1_message_digest_core] OK");
        else
            $display("[sha1_message_digest_core] ERROR");
        $finish;
    end

endmodule
